>>> rtl/sbda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants
// Sequencer states, ASCII codes and BCD correction constants for the decimal text converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_NINE  = 7'd57;
  localparam logic [6:0] CH_MINUS = 7'd45;

  // BCD digit correction threshold and offset for shift-and-add-3
  localparam logic [3:0] BCD_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ   = 4'd3;

endpackage
`default_nettype wire

>>> rtl/signed_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement value to its decimal characters, sign first.
// ----------------------------------------------------------------------------
// Each request carries one VALUE_WIDTH-bit two's complement integer; the block
// returns its decimal text one character at a time on the char channel,
// most significant character first, with last_char set on the final one. A
// negative value opens with '-', zero gives a single '0', and no leading
// zeros or terminator appear. The magnitude is taken as an unsigned number,
// so the most negative value converts exactly. Conversion runs on one
// shift-and-add-3 (double dabble) unit: it takes the request, shifts in the
// VALUE_WIDTH magnitude bits, drops the leading zero digits one at a time
// (NDIG minus the digit count of them), chooses between sign and digits, then
// sends the characters while the output side takes them, holding on a stall.
// value_stall stays high from acceptance until the last character has been
// loaded into the output register; the next request may be taken while that
// last character still waits. No state is kept between requests.
module signed_binary_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          value_valid,
  output logic                         value_stall,
  input  wire signed [VALUE_WIDTH-1:0] value,
  output logic                         char_valid,
  input  wire                          char_stall,
  output logic [6:0]                   ascii_char,
  output logic                         last_char
);

  // Decimal digits needed for a magnitude of up to 2^(VALUE_WIDTH-1)
  localparam int NDIG  = (VALUE_WIDTH * 301) / 1000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_W = $clog2(NDIG + 1);

  sbda_pkg::state_t state, state_next;

  logic [VALUE_WIDTH-1:0] bin, bin_next;
  logic [BCD_W-1:0]       bcd, bcd_next;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [DIG_W-1:0]       dcnt, dcnt_next;
  logic                   neg, neg_next;
  logic                   char_valid_next;
  logic [6:0]             ascii_char_next;
  logic                   last_char_next;
  logic                   slot_free;
  logic [3:0]             top_digit;

  assign value_stall = (state != sbda_pkg::ST_IDLE);
  assign slot_free   = !char_valid || !char_stall;
  assign top_digit   = bcd[BCD_W-1 -: 4];

  // Add 3 to every digit of 5 or more ahead of the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*4 +: 4] >= sbda_pkg::BCD_LIMIT) begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4] + sbda_pkg::BCD_ADJ;
      end else begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbda_pkg::ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state      <= state_next;
      char_valid <= char_valid_next;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    bin        <= bin_next;
    bcd        <= bcd_next;
    cnt        <= cnt_next;
    dcnt       <= dcnt_next;
    neg        <= neg_next;
    ascii_char <= ascii_char_next;
    last_char  <= last_char_next;
  end

  always_comb begin
    state_next      = state;
    bin_next        = bin;
    bcd_next        = bcd;
    cnt_next        = cnt;
    dcnt_next       = dcnt;
    neg_next        = neg;
    ascii_char_next = ascii_char;
    last_char_next  = last_char;
    // drop the held character once it has been taken
    char_valid_next = char_valid && char_stall;

    case (state)
      sbda_pkg::ST_IDLE: begin
        if (value_valid) begin
          // take the request and form the unsigned magnitude
          neg_next   = value[VALUE_WIDTH-1];
          bin_next   = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
          bcd_next   = '0;
          cnt_next   = CNT_W'(VALUE_WIDTH);
          state_next = sbda_pkg::ST_CONV;
        end
      end
      sbda_pkg::ST_CONV: begin
        // shift one magnitude bit into the corrected BCD word
        bcd_next = {bcd_adj[BCD_W-2:0], bin[VALUE_WIDTH-1]};
        bin_next = {bin[VALUE_WIDTH-2:0], 1'b0};
        cnt_next = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          dcnt_next  = DIG_W'(NDIG);
          state_next = sbda_pkg::ST_SKIP;
        end
      end
      sbda_pkg::ST_SKIP: begin
        // drop leading zero digits, always keeping the units digit
        if (top_digit == 4'd0 && dcnt != DIG_W'(1)) begin
          bcd_next  = {bcd[BCD_W-5:0], 4'd0};
          dcnt_next = dcnt - 1'b1;
        end else if (neg) begin
          state_next = sbda_pkg::ST_SIGN;
        end else begin
          state_next = sbda_pkg::ST_DIGITS;
        end
      end
      sbda_pkg::ST_SIGN: begin
        if (slot_free) begin
          ascii_char_next = sbda_pkg::CH_MINUS;
          last_char_next  = 1'b0;
          char_valid_next = 1'b1;
          state_next      = sbda_pkg::ST_DIGITS;
        end
      end
      sbda_pkg::ST_DIGITS: begin
        if (slot_free) begin
          // advance one digit, most significant first
          ascii_char_next = sbda_pkg::CH_ZERO + {3'b000, top_digit};
          last_char_next  = (dcnt == DIG_W'(1));
          char_valid_next = 1'b1;
          bcd_next        = {bcd[BCD_W-5:0], 4'd0};
          dcnt_next       = dcnt - 1'b1;
          if (dcnt == DIG_W'(1)) begin
            state_next = sbda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sbda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/sbda_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbda_checker: port-level checks for the decimal text converter
// Watches the request and character channels over time.
// ----------------------------------------------------------------------------
module sbda_checker (
  input wire       clk,
  input wire       rst,
  input wire       value_valid,
  input wire       value_stall,
  input wire       char_valid,
  input wire       char_stall,
  input wire [6:0] ascii_char,
  input wire       last_char
);

  // hold off further requests while one is being converted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (value_valid && !value_stall) |=> value_stall)
    else $error("request accepted while conversion should be busy");

  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_stall) |=>
      (char_valid && $stable(ascii_char) && $stable(last_char)))
    else $error("stalled character changed or dropped");

  a_char_code: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (ascii_char == sbda_pkg::CH_MINUS ||
                    (ascii_char >= sbda_pkg::CH_ZERO &&
                     ascii_char <= sbda_pkg::CH_NINE)))
    else $error("character is neither a digit nor a minus sign");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && ascii_char == sbda_pkg::CH_MINUS) |-> !last_char)
    else $error("minus sign flagged as final character");

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (.*);
`default_nettype wire

>>> tb/sbda_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbda_text_checker: decimal text scoreboard
// Watches both channels, works out the decimal characters of every accepted
// value and compares them in order with the characters that come out.
// ----------------------------------------------------------------------------
module sbda_text_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          value_valid,
  input  logic                          value_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          char_valid,
  input  logic                          char_stall,
  input  logic [6:0]                    ascii_char,
  input  logic                          last_char,
  output int                            errors,
  output int                            outstanding
);

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  text_char_t awaited_chars [$];
  int         err_count = 0;
  int         pending   = 0;

  // Append the decimal text of one value, sign first, to the awaited store
  task automatic queue_decimal_text(input logic [VALUE_WIDTH-1:0] raw);
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;
    text_char_t             text [$];
    text_char_t             entry;
    negative  = raw[VALUE_WIDTH-1];
    // unsigned negation keeps the most negative value exact
    magnitude = negative ? (~raw + 1'b1) : raw;
    if (magnitude == '0) begin
      entry.code = sbda_pkg::CH_ZERO;
      entry.last = 1'b0;
      text.push_front(entry);
    end
    while (magnitude != '0) begin
      entry.code = sbda_pkg::CH_ZERO + 7'(magnitude % 10);
      entry.last = 1'b0;
      text.push_front(entry);
      magnitude = magnitude / 10;
    end
    if (negative) begin
      entry.code = sbda_pkg::CH_MINUS;
      entry.last = 1'b0;
      text.push_front(entry);
    end
    text[text.size()-1].last = 1'b1;
    foreach (text[i]) awaited_chars.push_back(text[i]);
  endtask

  assign errors      = err_count;
  assign outstanding = pending;

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (value_valid && !value_stall) queue_decimal_text(value);
      if (char_valid && !char_stall) begin
        if (awaited_chars.size() == 0) begin
          $display("%0t: unexpected char %0d last_char %0b, nothing awaited",
                   $time, ascii_char, last_char);
          err_count++;
        end else begin
          want = awaited_chars.pop_front();
          if (ascii_char !== want.code) begin
            $display("%0t: ascii_char mismatch: expected %0d, actual %0d",
                     $time, want.code, ascii_char);
            err_count++;
          end
          if (last_char !== want.last) begin
            $display("%0t: last_char mismatch: expected %0b, actual %0b",
                     $time, want.last, last_char);
            err_count++;
          end
        end
      end
    end
    pending = awaited_chars.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: signed binary to decimal ASCII converter bench
// Drives directed and random values with random idling on both channels and
// leaves prediction and comparison to the text checker.
// ----------------------------------------------------------------------------
module tb;
  localparam int VALUE_WIDTH    = 32;
  localparam int RANDOM_ITEMS   = 95;
  localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES   = 80;    // beyond the worst conversion time
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request moving

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          value_valid = 1'b0;
  logic signed [VALUE_WIDTH-1:0] value       = '0;
  logic                          char_stall  = 1'b0;
  logic                          value_stall;
  logic                          char_valid;
  logic [6:0]                    ascii_char;
  logic                          last_char;

  int errors;
  int outstanding;
  int quiet_cycles;

  // Stimulus knobs: odds of a sender gap (1 in N, 0 for none), receiver
  // idling on or off, and a one-shot request for the long output hold-off.
  int tx_gap_odds    = 0;
  bit rx_busy        = 1'b0;
  bit long_hold_req  = 1'b0;

  logic signed [VALUE_WIDTH-1:0] directed_values [$] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    -32'sd100, 32'sd123456789, -32'sd987654321, 32'sd999999999,
    32'sd1000000000, -32'sd999999999, -32'sd1000000000, 32'sh7FFF_FFFF,
    32'sh8000_0000, 32'sh8000_0001, 32'sh5555_5555, 32'shAAAA_AAAA,
    -32'sd7, 32'sd65536
  };

  always #5 clk = ~clk;

  signed_binary_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value      (value),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ascii_char (ascii_char),
    .last_char  (last_char)
  );

  sbda_text_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) text_checker (
    .clk        (clk),
    .rst        (rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value      (value),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .ascii_char (ascii_char),
    .last_char  (last_char),
    .errors     (errors),
    .outstanding(outstanding)
  );

  // Offer one request, with an optional idle burst first. Valid stays high
  // across back-to-back requests, so it is only ever raised here, never
  // dropped and raised in the same step.
  task automatic offer_value(input logic signed [VALUE_WIDTH-1:0] v);
    if (tx_gap_odds != 0 && $urandom_range(1, tx_gap_odds) == 1) begin
      value_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    value_valid <= 1'b1;
    value       <= v;
    // hold the payload until the block takes it
    do @(posedge clk); while (value_stall);
  endtask

  // Drop valid and wait until every awaited character has come out. The
  // count is looked at on the falling edge, clear of the checker's updates.
  task automatic wait_for_text_drained();
    value_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Receiver: one stall decision per burst, so char_stall changes at most
  // once per edge. The long hold-off takes priority when requested.
  initial begin
    int span;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        char_stall <= 1'b1;
        span = LONG_HOLD;
      end else if (rx_busy && $urandom_range(0, 2) == 0) begin
        char_stall <= 1'b1;
        span = $urandom_range(1, 15);
      end else begin
        char_stall <= 1'b0;
        span = rx_busy ? $urandom_range(1, 12) : 1;
      end
      repeat (span) @(posedge clk);
    end
  end

  // Count cycles in which neither channel moves a request
  always @(posedge clk) begin
    if (rst || (value_valid && !value_stall) || (char_valid && !char_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic signed [VALUE_WIDTH-1:0] v;
    int unsigned                   tens;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, single digits, powers of ten on both sides of the
    // boundary, the extremes, the most negative value and alternating bits.
    rx_busy     = 1'b1;
    tx_gap_odds = 4;
    foreach (directed_values[i]) offer_value(directed_values[i]);

    // Hold the output off for a long stretch while requests keep coming, so
    // the block fills and stalls its input; then pause until all is out.
    long_hold_req = 1'b1;
    tx_gap_odds   = 0;
    repeat (5) offer_value($urandom());
    wait_for_text_drained();

    // Random: mixed magnitudes, powers of ten and their neighbours, values
    // near the extremes. Idling varies by stretch and stops at the end.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < 30) begin
        tx_gap_odds = 3;
        rx_busy     = 1'b1;
      end else if (i < 50) begin
        tx_gap_odds = 0;
        rx_busy     = 1'b1;
      end else if (i < 75) begin
        tx_gap_odds = 2;
        rx_busy     = 1'b0;
      end else begin
        tx_gap_odds = 0;
        rx_busy     = 1'b0;
      end
      case ($urandom_range(0, 4))
        0: v = $urandom();
        1: v = $urandom_range(0, 999);
        2: begin
          tens = 1;
          repeat ($urandom_range(0, 9)) tens = tens * 10;
          v = tens - $urandom_range(0, 1);
        end
        3: v = $urandom() >> $urandom_range(0, 31);
        default: v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
      endcase
      // flip the sign half the time; the maximum maps onto the most negative value
      if ($urandom_range(0, 1) == 1) v = -v - (v == 32'sh7FFF_FFFF ? 1 : 0);
      offer_value(v);
    end

    wait_for_text_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
